// File: sv/cb32ad_pkg.sv
// ----------------------------------------------------------------------------
// cb32ad_pkg
// Shared types, constants and the symbol lookup for the Crockford base32
// address decoder.
// ----------------------------------------------------------------------------
package cb32ad_pkg;

	localparam int unsigned SYM_W   = 8;
	localparam int unsigned DIGIT_W = 5;
	localparam int unsigned ADDR_W  = 128;
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned ALPHA_N = 32;

	localparam logic [SYM_W-1:0] CH_HYPHEN  = 8'h2D; // '-'
	localparam logic [SYM_W-1:0] CH_LOWER_A = 8'h61; // 'a'
	localparam logic [SYM_W-1:0] CH_LOWER_Z = 8'h7A; // 'z'
	localparam logic [SYM_W-1:0] CASE_DIFF  = 8'h20; // 'a' - 'A'

	// String packs its first character at the top: digit k is ALPHABET[ALPHA_N-1-k].
	localparam logic [ALPHA_N-1:0][SYM_W-1:0] ALPHABET = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             end_mark;
	} in_item_t;

	typedef struct packed {
		logic [HALF_W-1:0] address_high;
		logic [HALF_W-1:0] address_low;
		logic              decode_ok;
	} out_item_t;

	typedef struct packed {
		logic               hit;
		logic [DIGIT_W-1:0] value;
	} digit_t;

	// Fold a..z to upper case, then match against the alphabet.
	function automatic digit_t sym_lookup(input logic [SYM_W-1:0] ch);
		logic [SYM_W-1:0] up;
		digit_t           res;
		up = ch;
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			up = ch - CASE_DIFF;
		end
		res = '0;
		for (int k = 0; k < ALPHA_N; k++) begin
			if (ALPHABET[ALPHA_N-1-k] == up) begin
				res.hit   = 1'b1;
				res.value = DIGIT_W'(k);
			end
		end
		return res;
	endfunction

endpackage

// File: sv/crockford_base32_address_decoder_core.sv
// Path: an end request passes the input register, then the result register.
// Throughput: one request per cycle; the input register is refilled while a
//   result waits, and only an end request stalls behind an untaken result.
// Timing is set by the single alphabet lookup and 5-bit shift of the accumulator.
// Reset (arst_n low): input and output valid flags, accumulator and error clear.
// ----------------------------------------------------------------------------
// crockford_base32_address_decoder_core
// Streams characters into a 128-bit Crockford base32 accumulator and emits
// the decoded address plus an ok flag on each end request.
// ----------------------------------------------------------------------------
module crockford_base32_address_decoder_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cb32ad_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cb32ad_pkg::out_item_t out_data
);

	// Stage 1: registered input request.
	logic                 valid_s1;
	cb32ad_pkg::in_item_t data_s1;

	// Running state.
	logic [cb32ad_pkg::ADDR_W-1:0] accum_q;
	logic                          error_q;

	// Result register.
	logic                  out_valid_q;
	cb32ad_pkg::out_item_t out_data_q;

	logic               out_free;
	logic               s1_fire;
	logic               is_hyphen;
	cb32ad_pkg::digit_t digit;

	// Result slot can take a new value when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Character requests always retire; end requests need the result slot.
	assign s1_fire  = valid_s1 && (!data_s1.end_mark || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	assign is_hyphen = (data_s1.symbol == cb32ad_pkg::CH_HYPHEN);
	assign digit     = cb32ad_pkg::sym_lookup(data_s1.symbol);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Accumulator and sticky error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			error_q <= 1'b0;
		end else if (s1_fire) begin
			if (data_s1.end_mark) begin
				accum_q <= '0;
				error_q <= 1'b0;
			end else if (!is_hyphen) begin
				if (digit.hit) begin
					// shift in five bits, wrapping modulo 2^128
					accum_q <= {accum_q[cb32ad_pkg::ADDR_W-cb32ad_pkg::DIGIT_W-1:0],
						digit.value};
				end else begin
					error_q <= 1'b1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && data_s1.end_mark) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && data_s1.end_mark) begin
			if (error_q) begin
				out_data_q <= '0;
			end else begin
				out_data_q.address_high <= accum_q[cb32ad_pkg::ADDR_W-1:cb32ad_pkg::HALF_W];
				out_data_q.address_low  <= accum_q[cb32ad_pkg::HALF_W-1:0];
				out_data_q.decode_ok    <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A failed decode never reports a nonzero address.
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.decode_ok ||
			(out_data_q.address_high == '0 && out_data_q.address_low == '0)))
		else $error("invalid decode carries nonzero address");

	// An end request leaves the running state cleared.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && data_s1.end_mark) |=> (accum_q == '0 && !error_q))
		else $error("state not cleared after end request");

	// Input stalls only behind an end request waiting on the result slot.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && data_s1.end_mark && out_valid_q && !out_ready))
		else $error("unexpected input stall");

	// A character outside the alphabet raises the sticky error.
	a_bad_char: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !data_s1.end_mark && !is_hyphen && !digit.hit) |=> error_q)
		else $error("invalid character did not set error");

endmodule

// File: tb/tb_crockford_base32_address_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crockford_base32_address_decoder_core
// Streams character requests into the decoder and checks every emitted
// address against a behavioral decoder kept in a small scoreboard. A short
// directed list hits the edge cases. Random strings follow: mostly well-formed
// ones, some with bad characters and some pure noise. Random idle gaps and
// stalls fall on both handshakes, with stretches of neither.
// ----------------------------------------------------------------------------
module tb_crockford_base32_address_decoder_core;

	// Character codes used by the behavioral decoder and the stimulus
	localparam logic [7:0] HYPHEN_CHAR = 8'h2D; // '-'
	localparam logic [7:0] LOWER_A     = 8'h61; // 'a'
	localparam logic [7:0] LOWER_Z     = 8'h7A; // 'z'
	localparam logic [7:0] LETTER_A    = 8'h41; // 'A'
	localparam logic [7:0] CASE_GAP    = 8'h20; // 'a' - 'A'

	// Digit k sits at byte 31-k: the first character is packed at the top
	localparam logic [8*32-1:0] CROCKFORD = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

	localparam int TARGET_ITEMS = 1200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	// ------------------------------------------------------------------------
	// Scoreboard: decodes each accepted request on its own and queues the
	// expected address whenever an end request arrives.
	// ------------------------------------------------------------------------
	class address_scoreboard;
		logic [127:0]          accum;
		bit                    bad_char;
		int                    digit_count;
		cb32ad_pkg::out_item_t expected_addr[$];
		int                    errors;
		int                    strings_ok;
		int                    strings_bad;
		int                    longest;
		int                    checked;

		function new();
			accum       = '0;
			bad_char    = 1'b0;
			digit_count = 0;
			errors      = 0;
			strings_ok  = 0;
			strings_bad = 0;
			longest     = 0;
			checked     = 0;
		endfunction

		function void note_request(cb32ad_pkg::in_item_t req);
			logic [7:0]            ch;
			int                    val;
			cb32ad_pkg::out_item_t exp;
			if (req.end_mark) begin
				// symbol is don't-care on an end request
				exp.decode_ok    = !bad_char;
				exp.address_high = bad_char ? 64'd0 : accum[127:64];
				exp.address_low  = bad_char ? 64'd0 : accum[63:0];
				expected_addr.push_back(exp);
				if (bad_char) strings_bad++;
				else strings_ok++;
				if (digit_count > longest) longest = digit_count;
				accum       = '0;
				bad_char    = 1'b0;
				digit_count = 0;
			end else if (req.symbol != HYPHEN_CHAR) begin
				ch = req.symbol;
				if (ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_GAP;
				val = -1;
				for (int k = 0; k < 32; k++) begin
					if (CROCKFORD[8*(31-k) +: 8] == ch) val = k;
				end
				// a bad character is sticky but leaves the running value alone
				if (val < 0) begin
					bad_char = 1'b1;
				end else begin
					accum = {accum[122:0], val[4:0]};
					digit_count++;
				end
			end
		endfunction

		function void check_address(cb32ad_pkg::out_item_t got);
			cb32ad_pkg::out_item_t exp;
			if (expected_addr.size() == 0) begin
				$display("%0t: result with none expected: high=%h low=%h ok=%b",
					$time, got.address_high, got.address_low, got.decode_ok);
				errors++;
				return;
			end
			exp = expected_addr.pop_front();
			checked++;
			if (got.address_high !== exp.address_high) begin
				$display("%0t: address_high expected %h actual %h",
					$time, exp.address_high, got.address_high);
				errors++;
			end
			if (got.address_low !== exp.address_low) begin
				$display("%0t: address_low expected %h actual %h",
					$time, exp.address_low, got.address_low);
				errors++;
			end
			if (got.decode_ok !== exp.decode_ok) begin
				$display("%0t: decode_ok expected %b actual %b",
					$time, exp.decode_ok, got.decode_ok);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	cb32ad_pkg::in_item_t  in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	cb32ad_pkg::out_item_t out_data;

	// When set, neither side idles: back-to-back requests, results taken at once
	bit                    quiet     = 1'b0;
	int                    items_sent = 0;
	int                    cycles     = 0;
	address_scoreboard     sb         = new();

	crockford_base32_address_decoder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog: a correct run ends far below this
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, sb.expected_addr.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Result side: check at the handshake edge, then pick the next ready.
	// Values read right after the edge are the ones the edge sampled.
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_address(out_data);
			if (quiet) begin
				out_ready  <= 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready  <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side. valid is only lowered when a gap follows, so a
	// back-to-back request never sees a low and a high in one step.
	// ------------------------------------------------------------------------
	task automatic send_request(input cb32ad_pkg::in_item_t req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req);
		items_sent++;
	endtask

	task automatic send_char(input logic [7:0] ch);
		cb32ad_pkg::in_item_t req;
		req.symbol   = ch;
		req.end_mark = 1'b0;
		send_request(req);
	endtask

	task automatic send_end(input logic [7:0] junk);
		cb32ad_pkg::in_item_t req;
		req.symbol   = junk;
		req.end_mark = 1'b1;
		send_request(req);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	// One random string plus its end request.
	//   kind  0..69: well-formed, random case and hyphens
	//   kind 70..89: well-formed with at most one random byte dropped in
	//   kind 90..99: random bytes
	// About one in ten strings is 27 to 40 characters long, so the top bits usually wrap.
	task automatic send_random_string();
		int         kind;
		int         len;
		int         bad_pos;
		logic [7:0] ch;
		kind = $urandom_range(0, 99);
		len  = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 40) : $urandom_range(0, 26);
		if (kind >= 90) len = $urandom_range(0, 12);
		bad_pos = (kind >= 70 && kind < 90) ? $urandom_range(0, len) : -1;
		for (int i = 0; i < len; i++) begin
			if (kind >= 90 || i == bad_pos) begin
				ch = 8'($urandom);
			end else if ($urandom_range(0, 7) == 0) begin
				ch = HYPHEN_CHAR;
			end else begin
				ch = CROCKFORD[8*(31 - $urandom_range(0, 31)) +: 8];
				if (ch >= LETTER_A && $urandom_range(0, 1) == 1) ch = ch + CASE_GAP;
			end
			send_char(ch);
		end
		send_end(8'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string decodes to zero and is valid
		send_end(8'h00);
		// top digit in both cases, skipped hyphen; end symbol is ignored
		send_text("Zz-9");
		send_end(8'hFF);
		// lower-case u has no alias: error, decoding goes on after it
		send_text("1u2");
		send_end(8'h5A);
		// byte zero without the end mark is just a bad character
		send_char(8'h00);
		send_end(8'h00);
		// O, and bytes from the upper half are never folded
		send_text("O");
		send_char(8'h80);
		send_char(8'hFF);
		send_end(8'h2D);
		send_text("IL");
		send_end(8'h7F);
		// all-zero digit with repeated hyphens
		send_text("0--");
		send_end(8'h01);

		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 24) == 0) quiet <= !quiet;
			send_random_string();
		end
		in_valid <= 1'b0;
		quiet    <= 1'b0;

		while (sb.expected_addr.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d strings: %0d valid, %0d with bad characters",
			items_sent, sb.strings_ok + sb.strings_bad, sb.strings_ok, sb.strings_bad);
		$display("%0d addresses compared, longest string %0d digits, %0d mismatching fields",
			sb.checked, sb.longest, sb.errors);
		if (sb.expected_addr.size() != 0)
			$display("%0d expected addresses never arrived", sb.expected_addr.size());
		if (sb.errors == 0 && sb.expected_addr.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: files.f
sv/cb32ad_pkg.sv
sv/crockford_base32_address_decoder_core.sv
tb/tb_crockford_base32_address_decoder_core.sv
